// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the sync word hunter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SWHC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define SWHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/swhc_pkg.sv =====
// Types, constants and codes shared by the sync word hunter modules.
package swhc_pkg;

    localparam int HEADER_BYTES     = 12;
    localparam int SKIP_COUNT_WIDTH = 32;
    localparam int HEADER_MAX       = 12;
    localparam int HIDX_W           = $clog2(HEADER_BYTES);
    localparam int Q_DEPTH          = 4;
    localparam int Q_PTR_W          = $clog2(Q_DEPTH);
    localparam int Q_CNT_W          = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] SYNC_RESET = 32'hD41F8A37;

    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_FAIL = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_EOD   = 2'd1;
    localparam logic [1:0] ST_FAIL  = 2'd2;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_END  = 2'd1,
        CMD_FAIL = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PH_HUNT = 2'b01,
        PH_HEAD = 2'b10
    } t_phase;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        reversed_order;
        logic [31:0] header_word0;
        logic [31:0] header_word1;
        logic [31:0] header_word2;
        logic [31:0] skipped_bytes;
    } t_result;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_head;

endpackage

// ===== hw/rtl/swhc_front.sv =====
// Front end: classifies input words and buffers them in a short queue.
module swhc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  swhc_pkg::t_in_word i_word,
    output swhc_pkg::t_q_head  o_head,
    input  logic               i_pop
);

    swhc_pkg::t_q_entry                 r_mem [swhc_pkg::Q_DEPTH];
    logic [swhc_pkg::Q_PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [swhc_pkg::Q_PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [swhc_pkg::Q_CNT_W-1:0]       r_count, n_count;
    logic                               push;
    swhc_pkg::t_q_entry                 in_entry;

    assign o_stall = (r_count == swhc_pkg::Q_CNT_W'(swhc_pkg::Q_DEPTH));

    // Unused opcodes are accepted and dropped here.
    always_comb begin
        in_entry.data_byte = i_word.data_byte;
        in_entry.cmd       = swhc_pkg::CMD_BYTE;
        if (i_word.opcode == swhc_pkg::OP_END) begin
            in_entry.cmd = swhc_pkg::CMD_END;
        end else if (i_word.opcode == swhc_pkg::OP_FAIL) begin
            in_entry.cmd = swhc_pkg::CMD_FAIL;
        end
    end

    assign push = i_valid && !o_stall && (i_word.opcode != swhc_pkg::OP_NONE);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_entry;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

`include "assert_macros.svh"

    `SWHC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= swhc_pkg::Q_CNT_W'(swhc_pkg::Q_DEPTH), "queue count beyond depth")
    `SWHC_ASSERT(a_pop_nonempty, i_clk, i_rst_n, i_pop |-> (r_count != '0), "pop from empty queue")
    `SWHC_ASSERT(a_push_grows, i_clk, i_rst_n, (push && !i_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count did not grow on push")

endmodule

// ===== hw/rtl/swhc_back.sv =====
// Back end: sync word hunt, header capture and the result register.
module swhc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_data,
    input  swhc_pkg::t_q_head i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output swhc_pkg::t_result o_word
);

    localparam int SW = swhc_pkg::SKIP_COUNT_WIDTH;
    localparam int HW = swhc_pkg::HIDX_W;
    localparam logic [SW-1:0] SKIP_MAX = '1;

    logic [31:0]             r_sync_pattern;
    swhc_pkg::t_phase        r_phase, n_phase;
    logic [1:0]              r_match_pos, n_match_pos;
    logic                    r_order, n_order;
    logic [SW-1:0]           r_hunt_cnt, n_hunt_cnt;
    logic [HW-1:0]           r_hidx, n_hidx;
    logic [7:0]              r_store [swhc_pkg::HEADER_BYTES];
    logic                    r_out_valid, n_out_valid;
    swhc_pkg::t_result       r_out, res;

    logic                    is_byte, last_byte, produce, out_free, take;
    logic [7:0]              b, want;
    logic [7:0]              view [swhc_pkg::HEADER_MAX];
    logic [SW-1:0]           skip_raw;
    logic [63:0]             skip_ext;

    // Byte k of the pattern in forward order; byte 0 sits in bits 31:24.
    function automatic logic [7:0] pat_byte(input logic [31:0] p, input logic [1:0] k);
        return p[{~k, 3'b000} +: 8];
    endfunction

    assign b         = i_head.entry.data_byte;
    assign is_byte   = (i_head.entry.cmd == swhc_pkg::CMD_BYTE);
    assign last_byte = (r_hidx == HW'(swhc_pkg::HEADER_BYTES - 1));
    assign produce   = !is_byte || ((r_phase == swhc_pkg::PH_HEAD) && last_byte);
    assign out_free  = !r_out_valid || !i_stall;
    assign take      = i_head.valid && (!produce || out_free);
    assign o_pop     = take;

    assign want = r_order ? pat_byte(r_sync_pattern, ~r_match_pos)
                          : pat_byte(r_sync_pattern, r_match_pos);

    // Header view with the byte of this cycle placed at its slot.
    always_comb begin
        for (int i = 0; i < swhc_pkg::HEADER_MAX; i++) begin
            view[i] = 8'h00;
        end
        for (int i = 0; i < swhc_pkg::HEADER_BYTES; i++) begin
            view[i] = (r_hidx == HW'(i)) ? b : r_store[i];
        end
    end

    always_comb begin
        if (r_hunt_cnt == SKIP_MAX) begin
            skip_raw = SKIP_MAX;
        end else if (r_hunt_cnt >= SW'(4)) begin
            skip_raw = r_hunt_cnt - SW'(4);
        end else begin
            skip_raw = '0;
        end
        skip_ext = 64'(skip_raw);
    end

    always_comb begin
        res = '0;
        if (is_byte) begin
            res.status         = swhc_pkg::ST_FOUND;
            res.reversed_order = r_order;
            res.header_word0   = {view[3], view[2], view[1], view[0]};
            res.header_word1   = {view[7], view[6], view[5], view[4]};
            res.header_word2   = {view[11], view[10], view[9], view[8]};
            res.skipped_bytes  = (skip_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                             : skip_ext[31:0];
        end else if ((r_phase == swhc_pkg::PH_HUNT) &&
                     (i_head.entry.cmd == swhc_pkg::CMD_END)) begin
            res.status = swhc_pkg::ST_EOD;
        end else begin
            res.status = swhc_pkg::ST_FAIL;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_match_pos = r_match_pos;
        n_order     = r_order;
        n_hunt_cnt  = r_hunt_cnt;
        n_hidx      = r_hidx;
        if (take) begin
            if (produce) begin
                n_phase     = swhc_pkg::PH_HUNT;
                n_match_pos = '0;
                n_order     = 1'b0;
                n_hunt_cnt  = '0;
                n_hidx      = '0;
            end else if (r_phase == swhc_pkg::PH_HEAD) begin
                n_hidx = r_hidx + 1'b1;
            end else begin
                if (r_hunt_cnt != SKIP_MAX) begin
                    n_hunt_cnt = r_hunt_cnt + 1'b1;
                end
                if (r_match_pos == 2'd0) begin
                    if (b == pat_byte(r_sync_pattern, 2'd0)) begin
                        n_order     = 1'b0;
                        n_match_pos = 2'd1;
                    end else if (b == pat_byte(r_sync_pattern, 2'd3)) begin
                        n_order     = 1'b1;
                        n_match_pos = 2'd1;
                    end
                end else if (b != want) begin
                    n_match_pos = 2'd0;
                    n_order     = 1'b0;
                end else if (r_match_pos == 2'd3) begin
                    n_phase     = swhc_pkg::PH_HEAD;
                    n_match_pos = 2'd0;
                    n_hidx      = '0;
                end else begin
                    n_match_pos = r_match_pos + 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (take && produce) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pattern <= swhc_pkg::SYNC_RESET;
            r_phase        <= swhc_pkg::PH_HUNT;
            r_match_pos    <= '0;
            r_order        <= 1'b0;
            r_hunt_cnt     <= '0;
            r_hidx         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sync_pattern <= i_cfg_data;
            end
            r_phase     <= n_phase;
            r_match_pos <= n_match_pos;
            r_order     <= n_order;
            r_hunt_cnt  <= n_hunt_cnt;
            r_hidx      <= n_hidx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && is_byte && (r_phase == swhc_pkg::PH_HEAD)) begin
            r_store[r_hidx] <= b;
        end
        if (take && produce) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

`include "assert_macros.svh"

    `SWHC_ASSERT(a_head_no_match, i_clk, i_rst_n, (r_phase == swhc_pkg::PH_HEAD) |-> (r_match_pos == 2'd0), "match position left over in header capture")
    `SWHC_ASSERT(a_hidx_range, i_clk, i_rst_n, r_hidx <= HW'(swhc_pkg::HEADER_BYTES - 1), "header index out of range")
    `SWHC_ASSERT(a_error_zero, i_clk, i_rst_n, (r_out_valid && (r_out.status != swhc_pkg::ST_FOUND)) |-> ((r_out.skipped_bytes == '0) && !r_out.reversed_order && (r_out.header_word0 == '0)), "error result carries payload")
    `SWHC_ASSERT(a_hunt_idx_zero, i_clk, i_rst_n, (r_phase == swhc_pkg::PH_HUNT) |-> (r_hidx == '0), "header index moved while hunting")

endmodule

// ===== hw/rtl/sync_word_hunter_header_capture_core.sv =====
// Top level of the sync word hunter with header capture.
// The core scans a byte stream for a four-byte sync word (reset value 0xD41F8A37, set through
// i_cfg_we and i_cfg_data, to be written only while the core is idle; the core itself has no
// check for this) in forward or reversed byte order, then captures the next twelve header
// bytes and returns one word carrying the byte-order flag, three little-endian header words,
// the count of bytes skipped before the sync (saturating) and a status. An end-of-data word
// while hunting yields status 1; a read failure, or an end of data in the middle of a header,
// yields status 2 with all other fields zero. Opcode 3 is accepted and ignored. The core takes
// one input word every clock cycle as long as the result side keeps up: the front end writes
// each word into a four-entry queue and the hunt state machine in the back end retires one
// queued word per cycle. A result passes through the queue and is then registered in the
// output register, which raises o_valid; it waits there while the hunter keeps consuming
// bytes that produce no result. o_stall rises only when the queue is full, which happens when
// a finished result is held back by i_stall.
module sync_word_hunter_header_capture_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  swhc_pkg::t_in_word i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output swhc_pkg::t_result  o_word
);

    // Queue head seen by the back end, and its pop back to the front end.
    swhc_pkg::t_q_head q_head;
    logic              q_pop;

    // The front end classifies each word by opcode and queues it.
    swhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // The back end runs the hunt and capture and owns the result register.
    swhc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word)
    );

endmodule

// ===== dv/header_capture_checker.sv =====
// Checker that predicts and compares the result words of the sync word hunter.
module header_capture_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  swhc_pkg::t_in_word i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  swhc_pkg::t_result  i_out_word,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SKIP_SAT = {64{1'b1}} >> (64 - swhc_pkg::SKIP_COUNT_WIDTH);

    logic [31:0]       sync_word;
    swhc_pkg::t_phase  hunt_phase;
    logic [2:0]        match_pos;
    logic              reversed;
    logic [63:0]       hunt_count;
    logic [7:0]        header_bytes [swhc_pkg::HEADER_MAX];
    int                header_idx;
    swhc_pkg::t_result expected_headers [$];
    int                mismatches = 0;

    function automatic logic [7:0] sync_byte(int k);
        logic [31:0] s;
        s = sync_word >> (8 * (3 - (k & 3)));
        return s[7:0];
    endfunction

    function automatic void restart_hunt();
        hunt_phase = swhc_pkg::PH_HUNT;
        match_pos  = '0;
        reversed   = 1'b0;
        hunt_count = '0;
        header_idx = 0;
    endfunction

    function automatic logic [31:0] header_word(int base);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 4; k++) begin
            if (base + k < swhc_pkg::HEADER_BYTES && base + k < swhc_pkg::HEADER_MAX) begin
                w[8*k +: 8] = header_bytes[base + k];
            end
        end
        return w;
    endfunction

    // One input word through the hunter; sets produced when a result word comes out.
    task automatic predict_hunt_step(input swhc_pkg::t_in_word w, output bit produced,
                                     output swhc_pkg::t_result r);
        logic [7:0]  want;
        logic [63:0] skipped;
        produced = 1'b0;
        r        = '0;
        if (w.opcode == swhc_pkg::OP_NONE) begin
            return;
        end
        if (w.opcode != swhc_pkg::OP_DATA) begin
            r.status = (hunt_phase == swhc_pkg::PH_HUNT && w.opcode == swhc_pkg::OP_END) ?
                       swhc_pkg::ST_EOD : swhc_pkg::ST_FAIL;
            produced = 1'b1;
            restart_hunt();
            return;
        end
        if (hunt_phase == swhc_pkg::PH_HUNT) begin
            if (hunt_count < SKIP_SAT) begin
                hunt_count = hunt_count + 1;
            end
            if (match_pos == 0) begin
                if (w.data_byte == sync_byte(0)) begin
                    reversed  = 1'b0;
                    match_pos = 3'd1;
                end else if (w.data_byte == sync_byte(3)) begin
                    reversed  = 1'b1;
                    match_pos = 3'd1;
                end
            end else begin
                want = reversed ? sync_byte(3 - match_pos) : sync_byte(match_pos);
                if (w.data_byte != want) begin
                    match_pos = '0;
                    reversed  = 1'b0;
                end else begin
                    match_pos = match_pos + 3'd1;
                end
            end
            if (match_pos >= 3'd4) begin
                hunt_phase = swhc_pkg::PH_HEAD;
                header_idx = 0;
            end
            return;
        end
        if (header_idx < swhc_pkg::HEADER_MAX) begin
            header_bytes[header_idx] = w.data_byte;
        end
        header_idx++;
        if (header_idx >= swhc_pkg::HEADER_BYTES) begin
            if (hunt_count >= SKIP_SAT) begin
                skipped = SKIP_SAT;
            end else begin
                skipped = (hunt_count >= 4) ? hunt_count - 4 : '0;
            end
            if (skipped > 64'hFFFF_FFFF) begin
                skipped = 64'hFFFF_FFFF;
            end
            r.status         = swhc_pkg::ST_FOUND;
            r.reversed_order = reversed;
            r.header_word0   = header_word(0);
            r.header_word1   = header_word(4);
            r.header_word2   = header_word(8);
            r.skipped_bytes  = skipped[31:0];
            produced         = 1'b1;
            restart_hunt();
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        bit                produced;
        swhc_pkg::t_result predicted;
        swhc_pkg::t_result oldest;
        if (!i_rst_n) begin
            sync_word = swhc_pkg::SYNC_RESET;
            for (int k = 0; k < swhc_pkg::HEADER_MAX; k++) begin
                header_bytes[k] = '0;
            end
            restart_hunt();
            expected_headers.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_headers.size() == 0) begin
                    report_mismatch("result word arrived with none expected");
                end else begin
                    oldest = expected_headers.pop_front();
                    check_field("status", i_out_word.status, oldest.status);
                    check_field("reversed_order", i_out_word.reversed_order,
                                oldest.reversed_order);
                    check_field("header_word0", i_out_word.header_word0, oldest.header_word0);
                    check_field("header_word1", i_out_word.header_word1, oldest.header_word1);
                    check_field("header_word2", i_out_word.header_word2, oldest.header_word2);
                    check_field("skipped_bytes", i_out_word.skipped_bytes,
                                oldest.skipped_bytes);
                end
            end
            if (i_cfg_we) begin
                sync_word = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_hunt_step(i_in_word, produced, predicted);
                if (produced) begin
                    expected_headers.push_back(predicted);
                end
            end
        end
        o_pending    <= expected_headers.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== dv/tb.sv =====
// Top of the sync word hunter testbench: clock, reset, stimulus, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Queued words keep being retired while the result side keeps up, so this leaves ample
    // time for the queue to drain bytes that produce no result.
    localparam int DRAIN_CYCLES = 16;
    // Length of the deliberate output hold-off that fills the input queue.
    localparam int HOLD_CYCLES = 300;
    // Cycles without any accepted word before the run is declared hung.
    localparam int IDLE_LIMIT = 2000;

    logic               i_clk     = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [31:0]        cfg_data  = '0;
    logic               in_valid  = 1'b0;
    swhc_pkg::t_in_word in_word   = '0;
    logic               in_stall;
    logic               out_valid;
    logic               out_stall = 1'b0;
    swhc_pkg::t_result  out_word;
    int                 fail_count;
    int                 pending;

    // Stimulus bookkeeping. The current sync pattern is kept only to build frames.
    logic [31:0] cur_pattern = swhc_pkg::SYNC_RESET;
    int          items_sent  = 0;
    bit          tx_burst    = 1'b0;
    bit          rx_burst    = 1'b0;
    bit          hold_request = 1'b0;
    int          idle_cycles = 0;

    always #5ns i_clk = ~i_clk;

    sync_word_hunter_header_capture_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_word     (in_word),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_word     (out_word)
    );

    header_capture_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Reset is held at the start and never asserted again.
    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
    end

    // The watchdog counts cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("sync_word_hunter_header_capture_core test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side. Before every word it draws a random stall, except in burst stretches. When
    // asked, it holds off once for a long stretch so that a finished result is held in the
    // output register and the input queue behind it fills up.
    initial begin
        int n;
        int served;
        bit held;
        served = 0;
        held   = 1'b0;
        forever begin
            if (hold_request && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (served % 16 == 0) begin
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            n = rx_burst ? 0 : $urandom_range(0, 17);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
            served++;
        end
    end

    function automatic logic [7:0] pat_byte(int k);
        logic [31:0] s;
        s = cur_pattern >> (8 * (3 - k));
        return s[7:0];
    endfunction

    // Header content leans on the all-zero and all-one bytes now and then.
    function automatic logic [7:0] rand_byte();
        unique case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Noise often carries a pattern byte so that partial matches and false starts occur.
    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 3) == 0) begin
            return pat_byte($urandom_range(0, 3));
        end
        return rand_byte();
    endfunction

    // Offer one word after a random gap and wait until the core takes it. The valid stays
    // high across back-to-back words, so it is never lowered and raised in one step.
    task automatic send_word(input logic [1:0] op, input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= {op, b};
        do @(posedge i_clk); while (in_stall);
        if (op != swhc_pkg::OP_NONE) begin
            items_sent++;
        end
    endtask

    task automatic send_sync(input bit rev);
        for (int k = 0; k < 4; k++) begin
            send_word(swhc_pkg::OP_DATA, pat_byte(rev ? 3 - k : k));
        end
    endtask

    // Header bytes, with an occasional ignored opcode 3 word slipped in between them.
    task automatic send_header(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_word(swhc_pkg::OP_NONE, rand_byte());
            end
            send_word(swhc_pkg::OP_DATA, rand_byte());
        end
    endtask

    // Most frames are well formed: some noise, a sync word in either byte order and a full
    // header. The rest are broken syncs, truncated headers, bare end or failure words and ignored words.
    task automatic send_random_frame(input bit burst);
        int kind;
        int n;
        bit rev;
        kind     = burst ? 0 : $urandom_range(0, 99);
        tx_burst = burst || ($urandom_range(0, 3) == 0);
        rev      = 1'($urandom_range(0, 1));
        n        = $urandom_range(0, 5);
        repeat (n) send_word(swhc_pkg::OP_DATA, noise_byte());
        if (kind < 70) begin
            send_sync(rev);
            send_header(swhc_pkg::HEADER_BYTES);
        end else if (kind < 78) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                send_word(swhc_pkg::OP_DATA, pat_byte(rev ? 3 - k : k));
            end
            send_word(swhc_pkg::OP_DATA, rand_byte());
        end else if (kind < 86) begin
            send_sync(rev);
            send_header($urandom_range(0, swhc_pkg::HEADER_BYTES - 1));
            send_word($urandom_range(0, 1) ? swhc_pkg::OP_END : swhc_pkg::OP_FAIL,
                      rand_byte());
        end else if (kind < 92) begin
            send_word(swhc_pkg::OP_END, rand_byte());
        end else if (kind < 96) begin
            send_word(swhc_pkg::OP_FAIL, rand_byte());
        end else begin
            send_word(swhc_pkg::OP_NONE, rand_byte());
        end
    endtask

    // Lower the valid, wait for every expected result, then give the queue time to retire
    // bytes that produce no result. The first edge lets the pending count catch up.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The sync pattern is only changed while the core is idle.
    task automatic write_sync_pattern(input logic [31:0] value);
        wait_idle();
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        cur_pattern = value;
    endtask

    initial begin
        logic [31:0] patterns [5];
        int          quota;
        int          start;
        bit          hold_done;

        hold_done = 1'b0;

        // Later settings: both extremes, a pattern whose first and last bytes agree so
        // that a starting byte is ambiguous, a random one, and the reset value again.
        patterns[0] = 32'hFFFF_FFFF;
        patterns[1] = 32'h0000_0000;
        patterns[2] = $urandom();
        patterns[2][7:0] = patterns[2][31:24];
        patterns[3] = $urandom();
        patterns[4] = swhc_pkg::SYNC_RESET;

        wait (rst_n);
        @(posedge i_clk);

        // Directed words with the reset pattern. End of data and a read failure while
        // hunting, an ignored opcode, a forward frame with extreme header bytes, and a
        // reversed frame whose header is cut short by end of data.
        send_word(swhc_pkg::OP_END, 8'h00);
        send_word(swhc_pkg::OP_FAIL, 8'hFF);
        send_word(swhc_pkg::OP_NONE, 8'hA5);
        send_sync(1'b0);
        send_word(swhc_pkg::OP_DATA, 8'h00);
        send_word(swhc_pkg::OP_DATA, 8'hFF);
        send_header(swhc_pkg::HEADER_BYTES - 2);
        send_sync(1'b1);
        send_word(swhc_pkg::OP_DATA, 8'h5A);
        send_word(swhc_pkg::OP_END, 8'h00);

        // First random phase on the reset pattern. Partway in, the result side is asked
        // to hold off while frames stream in back to back, so the core must stall.
        start = items_sent;
        while (items_sent - start < 100) begin
            if (!hold_done && items_sent - start >= 40) begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
                repeat (6) send_random_frame(1'b1);
            end
            send_random_frame(1'b0);
        end

        // Further phases, each with a fresh sync pattern written while idle.
        for (int p = 0; p < 5; p++) begin
            write_sync_pattern(patterns[p]);
            quota = 60;
            start = items_sent;
            while (items_sent - start < quota) begin
                send_random_frame(1'b0);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("sync_word_hunter_header_capture_core test passed");
        end else begin
            $display("sync_word_hunter_header_capture_core test failed");
        end
        $finish;
    end

endmodule
